@@ rtl/sfc_pkg.sv @@
// ----------------------------------------------------------------------------
// sfc_pkg
// shared widths, register indexes, cull codes and types for the sphere
// frustum cull pipeline
// ----------------------------------------------------------------------------
package sfc_pkg;

   localparam int COORD_W   = 32;
   localparam int ROT_W     = 16;
   localparam int CSR_W     = 64;
   localparam int CSR_IDX_W = 3;
   localparam int ROW_W     = 3 * ROT_W;
   localparam int PROD_W    = ROT_W + COORD_W;
   localparam int R30_SHIFT = 14;
   localparam int R45_SHIFT = 29;
   localparam int TRANS_W   = COORD_W + R30_SHIFT;
   localparam int VIEW_W    = 50;
   localparam int CMP_W     = 52;
   localparam int SIDE_W    = VIEW_W + ROT_W + 1;
   localparam int PLANE_W   = 68;
   localparam int REASON_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_ROT_ROW0    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_ROW1    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_ROW2    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANS_X     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANS_Y     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANS_Z     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_COEFS = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_FAR    = 3'd7;

   localparam logic [ROW_W-1:0] ROT_ROW0_RST    = 48'h0000_0000_4000;
   localparam logic [ROW_W-1:0] ROT_ROW1_RST    = 48'h0000_4000_0000;
   localparam logic [ROW_W-1:0] ROT_ROW2_RST    = 48'h4000_0000_0000;
   localparam logic [CSR_W-1:0] PLANE_COEFS_RST = 64'h0000_8000_0000_8000;

   localparam logic [REASON_W-1:0] CULL_NONE   = 3'd0;
   localparam logic [REASON_W-1:0] CULL_BEHIND = 3'd1;
   localparam logic [REASON_W-1:0] CULL_FAR    = 3'd2;
   localparam logic [REASON_W-1:0] CULL_NEAR   = 3'd3;
   localparam logic [REASON_W-1:0] CULL_SIDE   = 3'd4;

   typedef struct packed {
      logic [ROW_W-1:0]   rot_row0;
      logic [ROW_W-1:0]   rot_row1;
      logic [ROW_W-1:0]   rot_row2;
      logic [COORD_W-1:0] trans_x;
      logic [COORD_W-1:0] trans_y;
      logic [COORD_W-1:0] trans_z;
   } sfc_xform_type;

   typedef struct packed {
      logic                     valid;
      logic signed [VIEW_W-1:0] vx;
      logic signed [VIEW_W-1:0] vy;
      logic signed [VIEW_W-1:0] vz;
      logic [COORD_W-1:0]       radius;
   } sfc_view_type;

endpackage

@@ rtl/sfc_transform.sv @@
// ----------------------------------------------------------------------------
// sfc_transform
// two-stage view transform: rotation products, then sum with translation
// ----------------------------------------------------------------------------
module sfc_transform import sfc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic signed [COORD_W-1:0] center_x,
   input  logic signed [COORD_W-1:0] center_y,
   input  logic signed [COORD_W-1:0] center_z,
   input  logic [COORD_W-1:0]        radius,
   input  sfc_xform_type             xform,
   output sfc_view_type              view
);

   logic signed [COORD_W-1:0] cen [3];
   logic [ROW_W-1:0]          rot [3];
   logic [COORD_W-1:0]        trn [3];

   logic signed [PROD_W-1:0]  prod_in  [3][3];
   logic signed [PROD_W-1:0]  prod_ff  [3][3];
   logic signed [TRANS_W-1:0] tt_in    [3];
   logic signed [TRANS_W-1:0] tt_ff    [3];
   logic [COORD_W-1:0]        rad1_ff;
   logic                      valid1_ff;
   logic signed [VIEW_W-1:0]  v_in     [3];
   sfc_view_type              view_ff;

   assign cen[0] = center_x;
   assign cen[1] = center_y;
   assign cen[2] = center_z;
   assign rot[0] = xform.rot_row0;
   assign rot[1] = xform.rot_row1;
   assign rot[2] = xform.rot_row2;
   assign trn[0] = xform.trans_x;
   assign trn[1] = xform.trans_y;
   assign trn[2] = xform.trans_z;

   // stage 1: nine rotation products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i][j] = PROD_W'($signed(rot[i][ROT_W*j +: ROT_W])) * PROD_W'(cen[j]);
         end
         tt_in[i] = $signed({trn[i], {R30_SHIFT{1'b0}}});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      tt_ff   <= tt_in;
      rad1_ff <= radius;
   end

   // stage 2: row sums
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         v_in[i] = VIEW_W'(prod_ff[i][0]) + VIEW_W'(prod_ff[i][1])
                 + VIEW_W'(prod_ff[i][2]) + VIEW_W'(tt_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         view_ff.valid <= 1'b0;
      end else begin
         view_ff.valid <= valid1_ff;
      end
      view_ff.vx     <= v_in[0];
      view_ff.vy     <= v_in[1];
      view_ff.vz     <= v_in[2];
      view_ff.radius <= rad1_ff;
   end

   assign view = view_ff;

endmodule

@@ rtl/sfc_test.sv @@
// ----------------------------------------------------------------------------
// sfc_test
// two-stage cull test: depth checks and plane products, then plane sums
// and priority of the cull reason
// ----------------------------------------------------------------------------
module sfc_test import sfc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  sfc_view_type        view,
   input  logic [CSR_W-1:0]    plane_coefs,
   input  logic [CSR_W-1:0]    near_far,
   output logic                rsp_valid,
   output logic                rsp_visible,
   output logic [REASON_W-1:0] rsp_cull_reason
);

   logic signed [CMP_W-1:0]  vz_c;
   logic signed [CMP_W-1:0]  az;
   logic signed [CMP_W-1:0]  r30;
   logic signed [CMP_W-1:0]  near30;
   logic signed [CMP_W-1:0]  far30;
   logic                     behind_in;
   logic                     far_in;
   logic                     near_in;
   logic signed [SIDE_W-1:0] au_in, bw_in, cv_in, dw_in;

   logic                     valid3_ff;
   logic                     behind_ff, far_ff, near_ff;
   logic signed [SIDE_W-1:0] au_ff, bw_ff, cv_ff, dw_ff;
   logic [COORD_W-1:0]       rad3_ff;

   logic signed [PLANE_W-1:0] au, bw, cv, dw, r45;
   logic signed [PLANE_W-1:0] left_s, right_s, bottom_s, top_s;
   logic                      side_out;
   logic [REASON_W-1:0]       reason_in;

   logic                      valid_ff;
   logic                      visible_ff;
   logic [REASON_W-1:0]       reason_ff;

   // stage 3: depth tests and plane products
   always_comb begin
      vz_c   = CMP_W'(view.vz);
      az     = vz_c[CMP_W-1] ? -vz_c : vz_c;
      r30    = $signed(CMP_W'({view.radius, {R30_SHIFT{1'b0}}}));
      near30 = $signed(CMP_W'({near_far[COORD_W-1:0], {R30_SHIFT{1'b0}}}));
      far30  = $signed(CMP_W'({near_far[CSR_W-1:COORD_W], {R30_SHIFT{1'b0}}}));
      behind_in = vz_c > r30;
      far_in    = (az - far30) > r30;
      near_in   = vz_c[CMP_W-1] && ((near30 - az) > r30);
      au_in = SIDE_W'(view.vx)
            * SIDE_W'($signed({1'b0, plane_coefs[ROT_W-1:0]}));
      bw_in = SIDE_W'(view.vz)
            * SIDE_W'($signed({1'b0, plane_coefs[2*ROT_W-1:ROT_W]}));
      cv_in = SIDE_W'(view.vy)
            * SIDE_W'($signed({1'b0, plane_coefs[3*ROT_W-1:2*ROT_W]}));
      dw_in = SIDE_W'(view.vz)
            * SIDE_W'($signed({1'b0, plane_coefs[4*ROT_W-1:3*ROT_W]}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
      end else begin
         valid3_ff <= view.valid;
      end
   end

   always_ff @(posedge clock) begin
      behind_ff <= behind_in;
      far_ff    <= far_in;
      near_ff   <= near_in;
      au_ff     <= au_in;
      bw_ff     <= bw_in;
      cv_ff     <= cv_in;
      dw_ff     <= dw_in;
      rad3_ff   <= view.radius;
   end

   // stage 4: side plane sums and reason priority
   always_comb begin
      au  = PLANE_W'(au_ff);
      bw  = PLANE_W'(bw_ff);
      cv  = PLANE_W'(cv_ff);
      dw  = PLANE_W'(dw_ff);
      r45 = $signed(PLANE_W'({rad3_ff, {R45_SHIFT{1'b0}}}));
      left_s   = au - bw + r45;
      right_s  = r45 - au - bw;
      bottom_s = cv - dw + r45;
      top_s    = r45 - cv - dw;
      side_out = left_s[PLANE_W-1] | right_s[PLANE_W-1]
               | bottom_s[PLANE_W-1] | top_s[PLANE_W-1];
      if (behind_ff) begin
         reason_in = CULL_BEHIND;
      end else if (far_ff) begin
         reason_in = CULL_FAR;
      end else if (near_ff) begin
         reason_in = CULL_NEAR;
      end else if (side_out) begin
         reason_in = CULL_SIDE;
      end else begin
         reason_in = CULL_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid3_ff;
      end
   end

   always_ff @(posedge clock) begin
      visible_ff <= (reason_in == CULL_NONE);
      reason_ff  <= reason_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_visible     = visible_ff;
   assign rsp_cull_reason = reason_ff;

endmodule

@@ rtl/sphere_frustum_cull_core.sv @@
// ----------------------------------------------------------------------------
// sphere_frustum_cull_core
// bounding sphere view frustum cull: view transform, depth and side plane
// tests, one sphere per clock
//
//   channel   ports                          flow
//   request   start, busy, req_*             start & !busy takes a transaction
//   response  rsp_valid, rsp_*               one-cycle strobe, no back pressure
//   csr       csr_we, csr_index, csr_wdata   write on csr_we, no read-back
//
// four register stages (products, row sums, depth tests and plane products,
// plane sums and reason)
// a new transaction is taken every cycle, busy stays low
// the response side cannot stall, so the pipeline never holds
// synchronous reset clears valid bits and loads the default registers
// ----------------------------------------------------------------------------
module sphere_frustum_cull_core import sfc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [COORD_W-1:0] req_center_x,
   input  logic signed [COORD_W-1:0] req_center_y,
   input  logic signed [COORD_W-1:0] req_center_z,
   input  logic [COORD_W-1:0]        req_radius,
   output logic                      rsp_valid,
   output logic                      rsp_visible,
   output logic [REASON_W-1:0]       rsp_cull_reason,
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_W-1:0]          csr_wdata
);

   logic [ROW_W-1:0]   rot_row0_ff, rot_row1_ff, rot_row2_ff;
   logic [COORD_W-1:0] trans_x_ff, trans_y_ff, trans_z_ff;
   logic [CSR_W-1:0]   plane_coefs_ff;
   logic [CSR_W-1:0]   near_far_ff;

   sfc_xform_type xform;
   sfc_view_type  view;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_row0_ff    <= ROT_ROW0_RST;
         rot_row1_ff    <= ROT_ROW1_RST;
         rot_row2_ff    <= ROT_ROW2_RST;
         trans_x_ff     <= '0;
         trans_y_ff     <= '0;
         trans_z_ff     <= '0;
         plane_coefs_ff <= PLANE_COEFS_RST;
         near_far_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROT_ROW0:    rot_row0_ff    <= csr_wdata[ROW_W-1:0];
            CSR_ROT_ROW1:    rot_row1_ff    <= csr_wdata[ROW_W-1:0];
            CSR_ROT_ROW2:    rot_row2_ff    <= csr_wdata[ROW_W-1:0];
            CSR_TRANS_X:     trans_x_ff     <= csr_wdata[COORD_W-1:0];
            CSR_TRANS_Y:     trans_y_ff     <= csr_wdata[COORD_W-1:0];
            CSR_TRANS_Z:     trans_z_ff     <= csr_wdata[COORD_W-1:0];
            CSR_PLANE_COEFS: plane_coefs_ff <= csr_wdata;
            CSR_NEAR_FAR:    near_far_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign xform.rot_row0 = rot_row0_ff;
   assign xform.rot_row1 = rot_row1_ff;
   assign xform.rot_row2 = rot_row2_ff;
   assign xform.trans_x  = trans_x_ff;
   assign xform.trans_y  = trans_y_ff;
   assign xform.trans_z  = trans_z_ff;

   assign busy = 1'b0;

   sfc_transform u_transform (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start & ~busy),
      .center_x (req_center_x),
      .center_y (req_center_y),
      .center_z (req_center_z),
      .radius   (req_radius),
      .xform    (xform),
      .view     (view)
   );

   sfc_test u_test (
      .clock           (clock),
      .reset           (reset),
      .view            (view),
      .plane_coefs     (plane_coefs_ff),
      .near_far        (near_far_ff),
      .rsp_valid       (rsp_valid),
      .rsp_visible     (rsp_visible),
      .rsp_cull_reason (rsp_cull_reason)
   );

   // every transaction comes out as a response after the full pipeline depth
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3) && !$past(reset, 4))
      |-> (rsp_valid == $past(start, 4)))
      else $error("response strobe does not follow request by pipeline depth");

   a_visible_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_visible == (rsp_cull_reason == CULL_NONE)))
      else $error("visible flag disagrees with cull reason");

   a_reason_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cull_reason == CULL_NONE || rsp_cull_reason == CULL_BEHIND ||
                     rsp_cull_reason == CULL_FAR || rsp_cull_reason == CULL_NEAR ||
                     rsp_cull_reason == CULL_SIDE))
      else $error("cull reason outside defined codes");

endmodule

@@ sim/cull_verdict_checker.sv @@
// ----------------------------------------------------------------------------
// cull_verdict_checker
// watches the request, response and csr ports of the sphere frustum cull
// core, keeps its own copy of the view registers, predicts visibility and
// cull reason for every accepted transaction and compares each response
// against the oldest prediction, counting failures for the testbench top
// ----------------------------------------------------------------------------
module cull_verdict_checker import sfc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic signed [COORD_W-1:0] req_center_x,
   input  logic signed [COORD_W-1:0] req_center_y,
   input  logic signed [COORD_W-1:0] req_center_z,
   input  logic [COORD_W-1:0]        req_radius,
   input  logic                      rsp_valid,
   input  logic                      rsp_visible,
   input  logic [REASON_W-1:0]       rsp_cull_reason,
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_W-1:0]          csr_wdata,
   output int                        fail_count,
   output int                        outstanding,
   output int                        checked_count,
   output int                        visible_count
);

   typedef struct packed {
      logic                visible;
      logic [REASON_W-1:0] reason;
   } verdict_type;

   logic [ROW_W-1:0]   rot_q   [3];
   logic [COORD_W-1:0] trans_q [3];
   logic [CSR_W-1:0]   planes_q;
   logic [CSR_W-1:0]   depth_q;
   verdict_type        pending_verdicts [$];
   int                 n_fail    = 0;
   int                 n_checked = 0;
   int                 n_visible = 0;
   int                 queued    = 0;

   assign fail_count    = n_fail;
   assign outstanding   = queued;
   assign checked_count = n_checked;
   assign visible_count = n_visible;

   // sign of p*u - q*w + r, p negated when flip is set, 45 fraction bits
   function automatic logic side_miss(input longint u, input logic [ROT_W-1:0] p,
                                      input bit flip, input longint w,
                                      input logic [ROT_W-1:0] q,
                                      input logic signed [127:0] r45);
      logic signed [127:0] uw;
      logic signed [127:0] ww;
      logic signed [127:0] pw;
      logic signed [127:0] qw;
      logic signed [127:0] acc;
      uw = u;
      ww = w;
      pw = {112'd0, p};
      qw = {112'd0, q};
      acc = uw * pw;
      if (flip)
         acc = -acc;
      acc = acc - ww * qw + r45;
      return acc[127];
   endfunction

   function automatic verdict_type predict_verdict(input logic signed [COORD_W-1:0] cx,
                                                   input logic signed [COORD_W-1:0] cy,
                                                   input logic signed [COORD_W-1:0] cz,
                                                   input logic [COORD_W-1:0] rad);
      longint              centre [3];
      longint              view   [3];
      longint              r30;
      longint              az;
      longint              near30;
      longint              far30;
      logic signed [127:0] r45;
      logic [ROT_W-1:0]    pa;
      logic [ROT_W-1:0]    pb;
      logic [ROT_W-1:0]    pc;
      logic [ROT_W-1:0]    pd;
      verdict_type         res;
      centre[0] = longint'(cx);
      centre[1] = longint'(cy);
      centre[2] = longint'(cz);
      for (int i = 0; i < 3; i++) begin
         view[i] = longint'($signed(trans_q[i])) <<< R30_SHIFT;
         for (int j = 0; j < 3; j++)
            view[i] += longint'($signed(rot_q[i][ROT_W*j +: ROT_W])) * centre[j];
      end
      r30    = longint'(rad) <<< R30_SHIFT;
      r45    = $signed({96'd0, rad}) <<< R45_SHIFT;
      az     = (view[2] < 0) ? -view[2] : view[2];
      near30 = longint'(depth_q[31:0]) <<< R30_SHIFT;
      far30  = longint'(depth_q[63:32]) <<< R30_SHIFT;
      pa     = planes_q[15:0];
      pb     = planes_q[31:16];
      pc     = planes_q[47:32];
      pd     = planes_q[63:48];
      if (view[2] > r30)
         res.reason = CULL_BEHIND;
      else if (az - far30 > r30)
         res.reason = CULL_FAR;
      else if (view[2] < 0 && near30 - az > r30)
         res.reason = CULL_NEAR;
      else if (side_miss(view[0], pa, 1'b0, view[2], pb, r45) ||
               side_miss(view[0], pa, 1'b1, view[2], pb, r45) ||
               side_miss(view[1], pc, 1'b0, view[2], pd, r45) ||
               side_miss(view[1], pc, 1'b1, view[2], pd, r45))
         res.reason = CULL_SIDE;
      else
         res.reason = CULL_NONE;
      res.visible = (res.reason == CULL_NONE);
      return res;
   endfunction

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         rot_q[0]   = ROT_ROW0_RST;
         rot_q[1]   = ROT_ROW1_RST;
         rot_q[2]   = ROT_ROW2_RST;
         trans_q[0] = '0;
         trans_q[1] = '0;
         trans_q[2] = '0;
         planes_q   = PLANE_COEFS_RST;
         depth_q    = '0;
         pending_verdicts.delete();
      end else begin
         if ($isunknown(rsp_valid)) begin
            $display("%0t: rsp_valid unknown, expected 0 or 1, actual %b", $time, rsp_valid);
            n_fail++;
         end else if (rsp_valid) begin
            if (pending_verdicts.size() == 0) begin
               $display("%0t: response with no transaction pending, expected none, actual %b/%0d",
                        $time, rsp_visible, rsp_cull_reason);
               n_fail++;
            end else begin
               want = pending_verdicts.pop_front();
               n_checked++;
               if (want.visible)
                  n_visible++;
               if (rsp_visible !== want.visible) begin
                  $display("%0t: visible mismatch, expected %b, actual %b",
                           $time, want.visible, rsp_visible);
                  n_fail++;
               end
               if (rsp_cull_reason !== want.reason) begin
                  $display("%0t: cull_reason mismatch, expected %0d, actual %0d",
                           $time, want.reason, rsp_cull_reason);
                  n_fail++;
               end
            end
         end
         if (start && !busy)
            pending_verdicts.push_back(predict_verdict(req_center_x, req_center_y,
                                                       req_center_z, req_radius));
         if (csr_we) begin
            case (csr_index)
               CSR_ROT_ROW0:    rot_q[0]   = csr_wdata[ROW_W-1:0];
               CSR_ROT_ROW1:    rot_q[1]   = csr_wdata[ROW_W-1:0];
               CSR_ROT_ROW2:    rot_q[2]   = csr_wdata[ROW_W-1:0];
               CSR_TRANS_X:     trans_q[0] = csr_wdata[COORD_W-1:0];
               CSR_TRANS_Y:     trans_q[1] = csr_wdata[COORD_W-1:0];
               CSR_TRANS_Z:     trans_q[2] = csr_wdata[COORD_W-1:0];
               CSR_PLANE_COEFS: planes_q   = csr_wdata;
               CSR_NEAR_FAR:    depth_q    = csr_wdata;
               default: ;
            endcase
         end
      end
      queued <= pending_verdicts.size();
   end

endmodule

@@ sim/tb_sphere_frustum_cull_core.sv @@
// ----------------------------------------------------------------------------
// tb_sphere_frustum_cull_core
// drives the sphere frustum cull core with directed spheres for every cull
// reason and its boundaries, then random spheres under a series of register
// settings (camera frusta, random, all-ones and all-zeros extremes), with
// random idle gaps; the checker module predicts and compares each response
// ----------------------------------------------------------------------------
module tb_sphere_frustum_cull_core;
   import sfc_pkg::*;

   localparam int ONE         = 32'h0001_0000;
   localparam int N_PHASES    = 10;
   localparam int PHASE_ITEMS = 38;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic signed [COORD_W-1:0] req_center_x;
   logic signed [COORD_W-1:0] req_center_y;
   logic signed [COORD_W-1:0] req_center_z;
   logic [COORD_W-1:0]        req_radius;
   logic                      rsp_valid;
   logic                      rsp_visible;
   logic [REASON_W-1:0]       rsp_cull_reason;
   logic                      csr_we;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_W-1:0]          csr_wdata;

   int fail_count;
   int outstanding;
   int checked_count;
   int visible_count;
   int setting_count = 1;
   bit no_idle       = 1'b0;

   sphere_frustum_cull_core dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_center_x    (req_center_x),
      .req_center_y    (req_center_y),
      .req_center_z    (req_center_z),
      .req_radius      (req_radius),
      .rsp_valid       (rsp_valid),
      .rsp_visible     (rsp_visible),
      .rsp_cull_reason (rsp_cull_reason),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   cull_verdict_checker verdicts (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_center_x    (req_center_x),
      .req_center_y    (req_center_y),
      .req_center_z    (req_center_z),
      .req_radius      (req_radius),
      .rsp_valid       (rsp_valid),
      .rsp_visible     (rsp_visible),
      .rsp_cull_reason (rsp_cull_reason),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .checked_count   (checked_count),
      .visible_count   (visible_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("sphere_frustum_cull_core regression: fail");
      $finish;
   end

   function automatic logic [ROW_W-1:0] pack_row(input logic [ROT_W-1:0] m0,
                                                 input logic [ROT_W-1:0] m1,
                                                 input logic [ROT_W-1:0] m2);
      return {m2, m1, m0};
   endfunction

   function automatic logic [ROT_W-1:0] rand_entry(input int span);
      return 16'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // upper bits beyond each register width are filled with noise
   task automatic apply_setting(input int kind);
      logic [ROW_W-1:0]   rows  [3];
      logic [COORD_W-1:0] shift [3];
      logic [CSR_W-1:0]   planes;
      logic [CSR_W-1:0]   depth;
      rows[0] = pack_row(16'h4000, 16'h0000, 16'h0000);
      rows[1] = pack_row(16'h0000, 16'h4000, 16'h0000);
      rows[2] = pack_row(16'h0000, 16'h0000, 16'h4000);
      for (int i = 0; i < 3; i++)
         shift[i] = '0;
      planes = {4{16'h5A82}};
      depth  = {32'(1000 * ONE), 32'(ONE)};
      case (kind)
         0: ;
         1: begin
            rows[0] = pack_row(16'h0000, 16'h0000, 16'hC000);
            rows[2] = pack_row(16'h4000, 16'h0000, 16'h0000);
            planes  = {16'h5A82, 16'h5A82, 16'h4000, 16'h6000};
            depth   = {32'(500 * ONE), 32'(ONE / 4)};
         end
         2: begin
            for (int i = 0; i < 3; i++) begin
               rows[i]  = pack_row(rand_entry(16'h4000), rand_entry(16'h4000),
                                   rand_entry(16'h4000));
               shift[i] = int'($urandom_range(0, 128 * ONE)) - 64 * ONE;
            end
            planes = {$urandom, $urandom};
            depth  = {32'($urandom_range(0, 2000 * ONE)), 32'($urandom_range(0, 8 * ONE))};
         end
         3: begin
            for (int i = 0; i < 3; i++) begin
               rows[i]  = 48'({$urandom, $urandom});
               shift[i] = $urandom;
            end
            planes = {$urandom, $urandom};
            depth  = {$urandom, $urandom};
         end
         4: begin
            for (int i = 0; i < 3; i++) begin
               rows[i]  = pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF);
               shift[i] = 32'h7FFF_FFFF;
            end
            planes = '1;
            depth  = '1;
         end
         5: begin
            for (int i = 0; i < 3; i++) begin
               rows[i]  = pack_row(16'h8000, 16'h8000, 16'h8000);
               shift[i] = 32'h8000_0000;
            end
            planes = '0;
            depth  = '0;
         end
         6: begin
            for (int i = 0; i < 3; i++) begin
               rows[i]  = '0;
               shift[i] = $urandom;
            end
            planes = {$urandom, $urandom};
            depth  = {$urandom, $urandom};
         end
         default: begin
            for (int i = 0; i < 3; i++)
               shift[i] = int'($urandom_range(0, 16 * ONE)) - 8 * ONE;
            depth = {32'hFFFF_FFFF, 32'd0};
         end
      endcase
      write_reg(CSR_ROT_ROW0, {16'($urandom), rows[0]});
      write_reg(CSR_ROT_ROW1, {16'($urandom), rows[1]});
      write_reg(CSR_ROT_ROW2, {16'($urandom), rows[2]});
      write_reg(CSR_TRANS_X, {$urandom, shift[0]});
      write_reg(CSR_TRANS_Y, {$urandom, shift[1]});
      write_reg(CSR_TRANS_Z, {$urandom, shift[2]});
      write_reg(CSR_PLANE_COEFS, planes);
      write_reg(CSR_NEAR_FAR, depth);
      setting_count++;
   endtask

   task automatic idle_gap();
      int pick;
      int n;
      if (no_idle)
         return;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         n = 0;
      else if (pick < 85)
         n = $urandom_range(1, 3);
      else if (pick < 97)
         n = $urandom_range(4, 12);
      else
         n = $urandom_range(20, 80);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_sphere(input int cx, input int cy, input int cz,
                              input logic [COORD_W-1:0] rad);
      idle_gap();
      start        <= 1'b1;
      req_center_x <= cx;
      req_center_y <= cy;
      req_center_z <= cz;
      req_radius   <= rad;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // mostly spheres around a camera looking down -z, the rest raw noise
   task automatic send_random();
      int               sel;
      int               cx;
      int               cy;
      int               cz;
      logic [COORD_W-1:0] rad;
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
         cx  = int'($urandom_range(0, 3200 * ONE)) - 1600 * ONE;
         cy  = int'($urandom_range(0, 3200 * ONE)) - 1600 * ONE;
         cz  = 20 * ONE - int'($urandom_range(0, 1220 * ONE));
         rad = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2 * ONE)
                                           : $urandom_range(0, 64 * ONE);
      end else if (sel < 9) begin
         cx  = $urandom;
         cy  = $urandom;
         cz  = $urandom;
         rad = $urandom;
      end else begin
         cx  = $urandom;
         cy  = $urandom;
         cz  = $urandom;
         case ($urandom_range(0, 2))
            0:       rad = '0;
            1:       rad = '1;
            default: rad = $urandom;
         endcase
      end
      send_sphere(cx, cy, cz, rad);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      reset        = 1'b1;
      start        = 1'b0;
      req_center_x = '0;
      req_center_y = '0;
      req_center_z = '0;
      req_radius   = '0;
      csr_we       = 1'b0;
      csr_index    = CSR_ROT_ROW0;
      csr_wdata    = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset registers: identity view, far and near at zero
      send_sphere(0, 0, 0, 0);
      send_sphere(0, 0, ONE, 0);
      send_sphere(0, 0, ONE, ONE);
      send_sphere(0, 0, -ONE, 0);
      send_sphere(2 * ONE, 0, 0, ONE);
      send_sphere(0, -2 * ONE, 0, ONE);
      send_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
      drain();

      // camera frustum: near 1.0, far 1000.0, 90 degree field of view
      apply_setting(0);
      send_sphere(0, 0, -10 * ONE, ONE);
      send_sphere(0, 0, -ONE / 2, ONE / 8);
      send_sphere(0, 0, -2000 * ONE, ONE);
      send_sphere(0, 0, 5 * ONE, ONE);
      send_sphere(100 * ONE, 0, -10 * ONE, ONE);
      send_sphere(-100 * ONE, 0, -10 * ONE, ONE);
      send_sphere(0, 100 * ONE, -10 * ONE, ONE);
      send_sphere(0, -100 * ONE, -10 * ONE, ONE);
      send_sphere(0, 0, -1001 * ONE, ONE);
      send_sphere(0, 0, -ONE / 2, ONE / 2);
      send_sphere(0, 0, 0, 32'hFFFF_FFFF);
      send_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0);
      send_sphere(100 * ONE, 0, 5 * ONE, 0);

      for (int p = 0; p < N_PHASES; p++) begin
         drain();
         apply_setting(p % 8);
         no_idle = ($urandom_range(0, 3) == 0);
         repeat (PHASE_ITEMS) send_random();
      end
      drain();

      $display("covered %0d spheres, %0d visible and %0d culled, over %0d register settings",
               checked_count, visible_count, checked_count - visible_count, setting_count);
      $display("settings: reset defaults, camera frusta, random, all-ones and all-zeros");
      if (fail_count == 0 && outstanding == 0)
         $display("sphere_frustum_cull_core regression: pass");
      else
         $display("sphere_frustum_cull_core regression: fail");
      $finish;
   end

endmodule
